/* sv/ffsa_pkg.sv */
// shared types and constants for the first-fit segment allocator
package ffsa_pkg;

  localparam int START_W  = 10;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // one free segment as held by a cell
  typedef struct packed {
    logic               vld;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } seg_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               alloc;
    logic               free;
    logic [LEN_W-1:0]   size;
  } cmd_t;

endpackage

/* sv/ffsa_if.sv */
// request and response channel interfaces
interface ffsa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ffsa_pkg::LEN_W-1:0]   block_size;
  logic [ffsa_pkg::START_W-1:0] block_offset;

  modport source (output valid, op, block_size, block_offset, input ready);
  modport sink   (input valid, op, block_size, block_offset, output ready);
endinterface

interface ffsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffsa_pkg::STATUS_W-1:0] status;
  logic [ffsa_pkg::START_W-1:0]  granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

/* sv/first_fit_segment_allocator_core.sv */
// first-fit segment allocator over a byte pool, built as a row of segment cells
//
// Each of the MAX_SEGMENTS cells holds one free segment (start, length) in table
// order; after reset cell 0 holds the whole pool of POOL_BYTES bytes (capped at
// 2047). A request is registered on acceptance and executed in S_EXEC once the
// output register can take the result: all cells compare their length against the
// request at once, a priority pick selects the first fit, and the row shifts by one
// place to remove an emptied segment or to insert a freed one at the front. A new
// request is taken in the cycle after the result is written to the output register,
// which may still be waiting for the consumer.
// Status is 0 when done, 1 when no segment fits and 2 when a free finds the
// table full; granted_offset is 0 except on a successful allocate.
module first_fit_segment_allocator_core #(
  parameter int POOL_BYTES   = 1024,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  ffsa_req_if.sink          req,
  ffsa_rsp_if.source        rsp
);
  import ffsa_pkg::*;

  localparam int N = MAX_SEGMENTS;
  localparam logic [LEN_W-1:0] POOL_LEN =
    (POOL_BYTES > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(POOL_BYTES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic               op;
  logic [LEN_W-1:0]   size;
  logic [START_W-1:0] offset;

  logic                out_vld;
  logic [STATUS_W-1:0] out_status;
  logic [START_W-1:0]  out_granted;

  seg_t         segs [N];
  logic [N-1:0] fits, exacts, low_mask, first, after;
  logic [START_W-1:0] granted;
  logic         any_fit, full, fire, drop;
  cmd_t         cmd;
  seg_t         head;

  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = out_vld;
  assign rsp.status         = out_status;
  assign rsp.granted_offset = out_granted;

  assign fire     = (state == S_EXEC) && (!out_vld || rsp.ready);
  assign low_mask = fits ^ (fits - N'(1));
  assign first    = fits & low_mask;
  assign after    = ~low_mask;
  assign any_fit  = |fits;
  assign full     = segs[N-1].vld;
  assign drop     = |(first & exacts);

  assign cmd.alloc = fire && (op == OP_ALLOC);
  assign cmd.free  = fire && (op == OP_FREE) && !full;
  assign cmd.size  = size;

  assign head.vld   = 1'b1;
  assign head.start = offset;
  assign head.len   = size;

  always_comb begin
    granted = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) granted = granted | segs[i].start;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    ffsa_cell #(
      .RESET_VLD ((g == 0) ? 1'b1 : 1'b0),
      .RESET_LEN ((g == 0) ? POOL_LEN : '0)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .drop  (drop),
      .first (first[g]),
      .after (after[g]),
      .left  ((g == 0) ? head : segs[(g == 0) ? 0 : g-1]),
      .right ((g == N-1) ? seg_t'('0) : segs[(g == N-1) ? g : g+1]),
      .seg   (segs[g]),
      .fit   (fits[g]),
      .exact (exacts[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op     <= req.op;
      size   <= req.block_size;
      offset <= req.block_offset;
    end
    if (fire) begin
      if (op == OP_ALLOC) begin
        out_status  <= any_fit ? ST_DONE : ST_NO_FIT;
        out_granted <= any_fit ? granted : '0;
      end else begin
        out_status  <= full ? ST_FULL : ST_DONE;
        out_granted <= '0;
      end
    end
  end

endmodule

/* sv/ffsa_cell.sv */
// one table position: holds a segment and shifts with its neighbors
module ffsa_cell #(
  parameter logic                       RESET_VLD = 1'b0,
  parameter logic [ffsa_pkg::LEN_W-1:0] RESET_LEN = '0
) (
  input  logic           clk,
  input  logic           rst,
  input  ffsa_pkg::cmd_t cmd,
  input  logic           drop,
  input  logic           first,
  input  logic           after,
  input  ffsa_pkg::seg_t left,
  input  ffsa_pkg::seg_t right,
  output ffsa_pkg::seg_t seg,
  output logic           fit,
  output logic           exact
);
  import ffsa_pkg::*;

  seg_t seg_next;

  assign fit   = seg.vld && (seg.len >= cmd.size);
  assign exact = seg.len == cmd.size;

  always_comb begin
    seg_next = seg;
    if (cmd.alloc && first && !drop) begin
      seg_next.start = seg.start + cmd.size[START_W-1:0];
      seg_next.len   = seg.len - cmd.size;
    end else if (cmd.alloc && drop && (first || after)) begin
      seg_next = right;
    end else if (cmd.free) begin
      seg_next = left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.vld   <= RESET_VLD;
      seg.start <= '0;
      seg.len   <= RESET_LEN;
    end else begin
      seg <= seg_next;
    end
  end

endmodule

/* verif/tb_first_fit_segment_allocator_core.sv */
// testbench for the first-fit segment allocator core: directed table and random traffic
module tb_first_fit_segment_allocator_core;
  import ffsa_pkg::*;

  localparam int POOL_BYTES   = 1024;
  localparam int MAX_SEGMENTS = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  offset;
  } grant_t;

  typedef struct {
    logic [START_W-1:0] offset;
    logic [LEN_W-1:0]   size;
  } held_block_t;

  typedef struct {
    logic                op;
    logic [LEN_W-1:0]    size;
    logic [START_W-1:0]  offset;
    int                  reps;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  granted;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  ffsa_req_if req ();
  ffsa_rsp_if rsp ();

  first_fit_segment_allocator_core #(
    .POOL_BYTES   (POOL_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  // predicted free list
  logic [START_W-1:0] free_start [MAX_SEGMENTS];
  logic [LEN_W-1:0]   free_len   [MAX_SEGMENTS];
  int                 free_count;

  grant_t      pending_grants [$];
  held_block_t held_blocks [$];
  int          errors = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  bit          offering = 1'b0;
  bit          no_gaps = 1'b0;
  int          burst_left = 1;
  int          cycle_count = 0;

  function automatic void reset_free_list();
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      free_start[i] = '0;
      free_len[i]   = '0;
    end
    free_len[0] = (POOL_BYTES > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(POOL_BYTES);
    free_count  = 1;
  endfunction

  function automatic grant_t apply_to_free_list(input logic op, input logic [LEN_W-1:0] size,
                                                input logic [START_W-1:0] offset);
    grant_t r;
    int     hit;
    r.status = ST_NO_FIT;
    r.offset = '0;
    hit      = -1;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < free_count; i++) begin
        if (hit < 0 && free_len[i] >= size) hit = i;
      end
      if (hit >= 0) begin
        r.status         = ST_DONE;
        r.offset         = free_start[hit];
        free_start[hit]  = START_W'(free_start[hit] + size);
        free_len[hit]    = free_len[hit] - size;
        if (free_len[hit] == '0) begin
          for (int j = hit; j + 1 < free_count; j++) begin
            free_start[j] = free_start[j+1];
            free_len[j]   = free_len[j+1];
          end
          free_count--;
          free_start[free_count] = '0;
          free_len[free_count]   = '0;
        end
      end
    end else if (free_count >= MAX_SEGMENTS) begin
      r.status = ST_FULL;
    end else begin
      for (int j = free_count; j > 0; j--) begin
        free_start[j] = free_start[j-1];
        free_len[j]   = free_len[j-1];
      end
      free_start[0] = offset;
      free_len[0]   = size;
      free_count++;
      r.status = ST_DONE;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return LEN_W'($urandom_range(1024, 2047));
    if (r < 12) return LEN_W'(1024);
    if (r < 30) return LEN_W'($urandom_range(65, 1023));
    return LEN_W'($urandom_range(1, 64));
  endfunction

  function automatic dir_row_t plan_row(input logic op, input int size, input int offset,
                                        input int reps, input bit typed,
                                        input logic [STATUS_W-1:0] status, input int granted);
    dir_row_t r;
    r.op      = op;
    r.size    = LEN_W'(size);
    r.offset  = START_W'(offset);
    r.reps    = reps;
    r.typed   = typed;
    r.status  = status;
    r.granted = START_W'(granted);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic offer(input logic op, input logic [LEN_W-1:0] size,
                       input logic [START_W-1:0] offset, input bit typed,
                       input logic [STATUS_W-1:0] status, input logic [START_W-1:0] granted);
    grant_t      pred;
    grant_t      want;
    held_block_t blk;
    int          gap;
    req.valid        <= 1'b1;
    req.op           <= op;
    req.block_size   <= size;
    req.block_offset <= offset;
    offering = 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pred = apply_to_free_list(op, size, offset);
    want = pred;
    if (typed) begin
      want.status = status;
      want.offset = granted;
    end
    pending_grants.push_back(want);
    if (op == OP_ALLOC && pred.status == ST_DONE && size != '0) begin
      blk.offset = pred.offset;
      blk.size   = size;
      held_blocks.push_back(blk);
    end
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          req.valid <= 1'b0;
          offering = 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic wait_all_granted();
    if (offering) begin
      req.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // response checking
  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("response with nothing expected, status %0d offset %0d",
                                  rsp.status, rsp.granted_offset));
      end else begin
        want = pending_grants.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        if (rsp.granted_offset !== want.offset)
          report_mismatch($sformatf("granted_offset %0d, expected %0d",
                                    rsp.granted_offset, want.offset));
      end
    end
  end

  // receiver stall pattern
  initial begin : rsp_stall_gen
    int mode;
    int left;
    int tick;
    mode = 0;
    left = 0;
    tick = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        tick++;
        case (mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= 1'($urandom_range(0, 1));
          2: rsp.ready <= ($urandom_range(0, 3) == 0);
          default: rsp.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    plan [21];
    held_block_t blk;
    int          kind;
    int          n;
    int          idx;
    logic        op;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.op           <= OP_ALLOC;
    req.block_size   <= '0;
    req.block_offset <= '0;
    reset_free_list();

    plan[0]  = plan_row(OP_ALLOC, 0,    1023, 1,  1, ST_DONE,   0);
    plan[1]  = plan_row(OP_ALLOC, 2047, 0,    1,  1, ST_NO_FIT, 0);
    plan[2]  = plan_row(OP_ALLOC, 1024, 0,    1,  1, ST_DONE,   0);
    plan[3]  = plan_row(OP_ALLOC, 0,    0,    1,  1, ST_NO_FIT, 0);
    plan[4]  = plan_row(OP_ALLOC, 1,    0,    1,  1, ST_NO_FIT, 0);
    plan[5]  = plan_row(OP_FREE,  0,    1023, 1,  1, ST_DONE,   0);
    plan[6]  = plan_row(OP_ALLOC, 0,    0,    1,  1, ST_DONE,   1023);
    plan[7]  = plan_row(OP_ALLOC, 0,    0,    1,  1, ST_NO_FIT, 0);
    plan[8]  = plan_row(OP_FREE,  2047, 1023, 1,  1, ST_DONE,   0);
    plan[9]  = plan_row(OP_ALLOC, 1,    0,    1,  1, ST_DONE,   1023);
    plan[10] = plan_row(OP_ALLOC, 2046, 0,    1,  1, ST_DONE,   0);
    plan[11] = plan_row(OP_FREE,  16,   100,  1,  0, ST_DONE,   0);
    plan[12] = plan_row(OP_FREE,  8,    200,  1,  0, ST_DONE,   0);
    plan[13] = plan_row(OP_ALLOC, 10,   0,    1,  0, ST_DONE,   0);
    plan[14] = plan_row(OP_ALLOC, 8,    0,    1,  0, ST_DONE,   0);
    plan[15] = plan_row(OP_FREE,  1,    5,    63, 0, ST_DONE,   0);
    plan[16] = plan_row(OP_FREE,  7,    300,  1,  1, ST_FULL,   0);
    plan[17] = plan_row(OP_ALLOC, 2047, 0,    1,  1, ST_NO_FIT, 0);
    plan[18] = plan_row(OP_ALLOC, 6,    0,    1,  0, ST_DONE,   0);
    plan[19] = plan_row(OP_FREE,  1024, 0,    1,  0, ST_DONE,   0);
    plan[20] = plan_row(OP_ALLOC, 1024, 0,    1,  0, ST_DONE,   0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      repeat (plan[r].reps)
        offer(plan[r].op, plan[r].size, plan[r].offset, plan[r].typed,
              plan[r].status, plan[r].granted);
    end
    wait_all_granted();

    for (int ph = 0; ph < 16; ph++) begin
      kind = ph % 4;
      n = $urandom_range(100, 120);
      no_gaps = (ph == 5 || ph == 9);
      if (ph == 5) hold_requests++;
      repeat (n) begin
        case (kind)
          0: op = ($urandom_range(0, 3) != 0) ? OP_FREE : OP_ALLOC;
          1: op = ($urandom_range(0, 3) == 0) ? OP_FREE : OP_ALLOC;
          default: op = 1'($urandom_range(0, 1));
        endcase
        if (op == OP_FREE && held_blocks.size() != 0 && kind != 2 &&
            $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, held_blocks.size() - 1);
          blk = held_blocks[idx];
          held_blocks.delete(idx);
          offer(OP_FREE, blk.size, blk.offset, 1'b0, ST_DONE, '0);
        end else begin
          offer(op, pick_size(), START_W'($urandom_range(0, 1023)), 1'b0, ST_DONE, '0);
        end
      end
      wait_all_granted();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
